/* rtl/core/min_jerk_trajectory_generator_top_macros.svh */
// ----------------------------------------------------------------------------
// Minimum-jerk trajectory generator assertion macros
// Concurrent check helpers, clocked on clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef MIN_JERK_TRAJECTORY_GENERATOR_TOP_MACROS_SVH
`define MIN_JERK_TRAJECTORY_GENERATOR_TOP_MACROS_SVH

// same-cycle implication
`define MJT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mjt assertion failed");

// next-cycle implication
`define MJT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mjt assertion failed");

`endif

/* rtl/core/mjt_pkg.sv */
// ----------------------------------------------------------------------------
// mjt_pkg
// Shared types and constants of the minimum-jerk trajectory generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mjt_pkg;

	localparam int TIME_BITS_DEF = 24;
	localparam int FRAC_BITS     = 30;
	localparam int MAG_W         = 32;
	localparam int S_W           = FRAC_BITS + 1;
	localparam int SU_W          = 29;
	localparam int G_W           = 27;
	localparam int Q_W           = 34;
	localparam int XV_W          = MAG_W + G_W;
	localparam int VNUM_W        = 40;
	localparam int CFG_IDX_W     = 3;

	localparam logic [S_W-1:0] ONE_Q30 = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [Q_W:0]   TEN_Q30 = (Q_W + 1)'(10) << FRAC_BITS;

	typedef enum logic [1:0] {
		FN_MRB  = 2'd0,
		FN_POSE = 2'd1,
		FN_VEL  = 2'd2,
		FN_NONE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		MD_ZERO = 2'd0,
		MD_HOLD = 2'd1,
		MD_POS  = 2'd2,
		MD_VEL  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AMPLITUDE = 3'd0,
		REG_START     = 3'd1,
		REG_MOVE      = 3'd2,
		REG_REST      = 3'd3,
		REG_RETURN    = 3'd4
	} reg_idx_t;

	// per-item control carried down the pipeline
	typedef struct packed {
		mode_t            mode;
		logic             neg;
		logic [MAG_W-1:0] mag;
	} ctl_t;

endpackage

`default_nettype wire

/* rtl/core/mjt_seg.sv */
// ----------------------------------------------------------------------------
// mjt_seg
// Segment decode: picks the profile segment, elapsed ticks and ramp length.
// ----------------------------------------------------------------------------
`default_nettype none

module mjt_seg import mjt_pkg::*; #(
	parameter int TB = TIME_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_i,
	input  logic [TB-1:0]    time_i,
	input  logic [1:0]       func_i,
	input  logic [MAG_W-1:0] amp_i,
	input  logic [TB-1:0]    start_i,
	input  logic [TB-1:0]    move_i,
	input  logic [TB-1:0]    rest_i,
	input  logic [TB-1:0]    ret_i,
	output logic             vld_s1,
	output ctl_t             ctl_s1,
	output logic [TB-1:0]    e_s1,
	output logic [TB-1:0]    den_s1,
	output logic             full_s1
);

	logic [TB+1:0] tt, st, me, re, te, dret;
	ctl_t          ctl_c;
	logic [TB-1:0] e_c, den_c;
	logic          full_c;

	assign tt   = {2'b00, time_i};
	assign st   = {2'b00, start_i};
	assign me   = st + {2'b00, move_i};
	assign re   = me + {2'b00, rest_i};
	assign te   = re + {2'b00, ret_i};
	assign dret = te - tt;

	always_comb begin
		ctl_c.neg  = amp_i[MAG_W-1];
		ctl_c.mag  = amp_i[MAG_W-1] ? (~amp_i + MAG_W'(1)) : amp_i;
		ctl_c.mode = MD_ZERO;
		e_c        = (tt - st) >> 0 == '0 ? '0 : TB'(tt - st);
		den_c      = move_i;
		full_c     = 1'b0;
		priority if (tt < st || func_t'(func_i) == FN_NONE) begin
			ctl_c.mode = MD_ZERO;
		end else begin
			unique case (func_t'(func_i))
				FN_MRB: begin
					priority if (tt < me) begin
						ctl_c.mode = MD_POS;
					end else if (tt < re) begin
						ctl_c.mode = MD_HOLD;
					end else if (tt < te) begin
						// return ramp runs backward from its end
						ctl_c.mode = MD_POS;
						e_c        = dret[TB-1:0];
						den_c      = ret_i;
						full_c     = (dret[TB-1:0] == ret_i);
					end else begin
						ctl_c.mode = MD_ZERO;
					end
				end
				FN_POSE: ctl_c.mode = (tt < me) ? MD_POS : MD_HOLD;
				FN_VEL:  ctl_c.mode = (tt < me) ? MD_VEL : MD_ZERO;
				default: ctl_c.mode = MD_ZERO;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1  <= ctl_c;
			e_s1    <= e_c;
			den_s1  <= den_c;
			full_s1 <= full_c;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/mjt_fdiv.sv */
// ----------------------------------------------------------------------------
// mjt_fdiv
// Pipelined fraction divider: s = floor(e * 2^30 / T), one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mjt_fdiv import mjt_pkg::*; #(
	parameter int TB = TIME_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_i,
	input  ctl_t           ctl_i,
	input  logic [TB-1:0]  e_i,
	input  logic [TB-1:0]  den_i,
	input  logic           full_i,
	output logic           vld_o,
	output ctl_t           ctl_o,
	output logic [S_W-1:0] s_o,
	output logic [TB-1:0]  den_o
);

	logic                 vld_sk  [FRAC_BITS];
	ctl_t                 ctl_sk  [FRAC_BITS];
	logic [TB-1:0]        den_sk  [FRAC_BITS];
	logic [TB-1:0]        rem_sk  [FRAC_BITS];
	logic [FRAC_BITS-1:0] quo_sk  [FRAC_BITS];
	logic                 full_sk [FRAC_BITS];

	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
		logic                 vld_p, full_p, ge;
		ctl_t                 ctl_p;
		logic [TB-1:0]        den_p, rem_p;
		logic [FRAC_BITS-1:0] quo_p;
		logic [TB:0]          dbl, diff;

		if (k == 0) begin : g_first
			assign vld_p  = vld_i;
			assign ctl_p  = ctl_i;
			assign den_p  = den_i;
			assign rem_p  = e_i;
			assign quo_p  = '0;
			assign full_p = full_i;
		end else begin : g_next
			assign vld_p  = vld_sk[k-1];
			assign ctl_p  = ctl_sk[k-1];
			assign den_p  = den_sk[k-1];
			assign rem_p  = rem_sk[k-1];
			assign quo_p  = quo_sk[k-1];
			assign full_p = full_sk[k-1];
		end

		assign dbl  = {rem_p, 1'b0};
		assign diff = dbl - {1'b0, den_p};
		assign ge   = (dbl >= {1'b0, den_p});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k] <= 1'b0;
			end else if (en) begin
				vld_sk[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_sk[k]  <= ctl_p;
				den_sk[k]  <= den_p;
				rem_sk[k]  <= ge ? diff[TB-1:0] : dbl[TB-1:0];
				quo_sk[k]  <= {quo_p[FRAC_BITS-2:0], ge};
				full_sk[k] <= full_p;
			end
		end
	end

	assign vld_o = vld_sk[FRAC_BITS-1];
	assign ctl_o = ctl_sk[FRAC_BITS-1];
	assign den_o = den_sk[FRAC_BITS-1];
	// elapsed equal to the length means the full fraction
	assign s_o   = full_sk[FRAC_BITS-1] ? ONE_Q30 : {1'b0, quo_sk[FRAC_BITS-1]};

endmodule

`default_nettype wire

/* rtl/core/mjt_poly.sv */
// ----------------------------------------------------------------------------
// mjt_poly
// Quintic polynomial and velocity numerator, four multiply stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mjt_poly import mjt_pkg::*; #(
	parameter int TB = TIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  ctl_t              ctl_i,
	input  logic [S_W-1:0]    s_i,
	input  logic [TB-1:0]     den_i,
	output logic              vld_s4,
	output ctl_t              ctl_s4,
	output logic [MAG_W-1:0]  pm_s4,
	output logic [VNUM_W-1:0] vn_s4,
	output logic [TB-1:0]     den_s4
);

	logic              vld_s1, vld_s2, vld_s3;
	ctl_t              ctl_s1, ctl_s2, ctl_s3;
	logic [TB-1:0]     den_s1, den_s2, den_s3;
	logic [S_W-1:0]    s_s1, s2_s1, s3_s2, f_s3;
	logic [SU_W-1:0]   su_s1;
	logic [G_W-1:0]    g_s2;
	logic [Q_W-1:0]    q_s2;
	logic [XV_W-1:0]   xv_s3;

	logic [2*S_W-1:0]     sq_c, su_c, s3_c;
	logic [S_W-1:0]       u_c;
	logic [2*SU_W-1:0]    g_c;
	logic [Q_W:0]         q_c;
	logic [S_W+Q_W-1:0]   f_c;
	logic [MAG_W+S_W-1:0] pm_c;
	logic [XV_W+12:0]     xs_c;

	assign sq_c = s_i * s_i;
	assign u_c  = ONE_Q30 - s_i;
	assign su_c = s_i * u_c;

	assign s3_c = s2_s1 * s_s1;
	assign g_c  = su_s1 * su_s1;
	assign q_c  = TEN_Q30 + ({4'b0, s2_s1} * (Q_W + 1)'(6)) - ({4'b0, s_s1} * (Q_W + 1)'(15));

	assign f_c  = s3_s2 * q_s2;

	assign pm_c = ctl_s3.mag * f_s3;
	// times 7680 = 2^13 - 2^9
	assign xs_c = {xv_s3, 13'b0} - {4'b0, xv_s3, 9'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl_i;
			den_s1 <= den_i;
			s_s1   <= s_i;
			s2_s1  <= sq_c[FRAC_BITS+S_W-1:FRAC_BITS];
			su_s1  <= su_c[FRAC_BITS+SU_W-1:FRAC_BITS];

			ctl_s2 <= ctl_s1;
			den_s2 <= den_s1;
			s3_s2  <= s3_c[FRAC_BITS+S_W-1:FRAC_BITS];
			g_s2   <= g_c[FRAC_BITS+G_W-1:FRAC_BITS];
			q_s2   <= q_c[Q_W-1:0];

			ctl_s3 <= ctl_s2;
			den_s3 <= den_s2;
			f_s3   <= f_c[FRAC_BITS+S_W-1:FRAC_BITS];
			xv_s3  <= ctl_s2.mag * g_s2;

			ctl_s4 <= ctl_s3;
			den_s4 <= den_s3;
			pm_s4  <= pm_c[FRAC_BITS+MAG_W-1:FRAC_BITS];
			vn_s4  <= xs_c[FRAC_BITS+VNUM_W-1:FRAC_BITS];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/mjt_vdiv.sv */
// ----------------------------------------------------------------------------
// mjt_vdiv
// Pipelined velocity divider: floor(num / T), one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mjt_vdiv import mjt_pkg::*; #(
	parameter int TB = TIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  ctl_t              ctl_i,
	input  logic [MAG_W-1:0]  pm_i,
	input  logic [VNUM_W-1:0] vn_i,
	input  logic [TB-1:0]     den_i,
	output logic              vld_o,
	output ctl_t              ctl_o,
	output logic [MAG_W-1:0]  pm_o,
	output logic [VNUM_W-1:0] vq_o
);

	logic              vld_sk [VNUM_W];
	ctl_t              ctl_sk [VNUM_W];
	logic [MAG_W-1:0]  pm_sk  [VNUM_W];
	logic [VNUM_W-1:0] num_sk [VNUM_W];
	logic [VNUM_W-1:0] quo_sk [VNUM_W];
	logic [TB-1:0]     den_sk [VNUM_W];
	logic [TB-1:0]     rem_sk [VNUM_W];

	for (genvar k = 0; k < VNUM_W; k++) begin : g_stage
		logic              vld_p, ge;
		ctl_t              ctl_p;
		logic [MAG_W-1:0]  pm_p;
		logic [VNUM_W-1:0] num_p, quo_p;
		logic [TB-1:0]     den_p, rem_p;
		logic [TB:0]       dbl, diff;

		if (k == 0) begin : g_first
			assign vld_p = vld_i;
			assign ctl_p = ctl_i;
			assign pm_p  = pm_i;
			assign num_p = vn_i;
			assign quo_p = '0;
			assign den_p = den_i;
			assign rem_p = '0;
		end else begin : g_next
			assign vld_p = vld_sk[k-1];
			assign ctl_p = ctl_sk[k-1];
			assign pm_p  = pm_sk[k-1];
			assign num_p = num_sk[k-1];
			assign quo_p = quo_sk[k-1];
			assign den_p = den_sk[k-1];
			assign rem_p = rem_sk[k-1];
		end

		// bring down the next numerator bit
		assign dbl  = {rem_p, num_p[VNUM_W-1-k]};
		assign diff = dbl - {1'b0, den_p};
		assign ge   = (dbl >= {1'b0, den_p});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k] <= 1'b0;
			end else if (en) begin
				vld_sk[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_sk[k] <= ctl_p;
				pm_sk[k]  <= pm_p;
				num_sk[k] <= num_p;
				den_sk[k] <= den_p;
				rem_sk[k] <= ge ? diff[TB-1:0] : dbl[TB-1:0];
				quo_sk[k] <= {quo_p[VNUM_W-2:0], ge};
			end
		end
	end

	assign vld_o = vld_sk[VNUM_W-1];
	assign ctl_o = ctl_sk[VNUM_W-1];
	assign pm_o  = pm_sk[VNUM_W-1];
	assign vq_o  = quo_sk[VNUM_W-1];

endmodule

`default_nettype wire

/* rtl/core/min_jerk_trajectory_generator_top.sv */
// ----------------------------------------------------------------------------
// Minimum-jerk trajectory generator
// Evaluates a quintic minimum-jerk joint profile at one sample time per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries sample_time and func; output
//   channel (out_valid/out_stall) returns one saturated Q16.16 setpoint per
//   input transaction, in order. func 0 is move-rest-back position, 1 is
//   move-to-pose position, 2 is move-to-pose velocity per 256 ticks, 3 gives 0.
//   Profile registers are written through cfg_we/cfg_idx/cfg_wdata. The user
//   must write only while the pipeline holds no transaction; the block does not check.
//   A transaction passes 76 registers: 1 decode, 30 fraction divider,
//   4 multiply, 40 velocity divider, 1 output register. The first loads at
//   the accepting edge. The pipeline accepts one transaction every cycle
//   unless out_stall holds a result; the two bit-serial dividers set the
//   depth.
//   Reset clears the profile registers and all valid bits; the profile
//   starts all zero.
//   While a result waits under out_stall the whole pipeline holds and
//   in_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module min_jerk_trajectory_generator_top import mjt_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [TIME_BITS-1:0]    sample_time,
	input  logic [1:0]              func,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [MAG_W-1:0] setpoint,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_idx,
	input  logic [MAG_W-1:0]        cfg_wdata
);

	`include "min_jerk_trajectory_generator_top_macros.svh"

	logic [MAG_W-1:0]     amp_q;
	logic [TIME_BITS-1:0] start_q, move_q, rest_q, ret_q;

	logic                 adv;
	logic                 out_valid_q;
	logic [MAG_W-1:0]     setpoint_q;

	logic                 seg_vld, seg_full, fd_vld, pl_vld, vd_vld;
	ctl_t                 seg_ctl, fd_ctl, pl_ctl, vd_ctl;
	logic [TIME_BITS-1:0] seg_e, seg_den, fd_den, pl_den;
	logic [S_W-1:0]       fd_s;
	logic [MAG_W-1:0]     pl_pm, vd_pm;
	logic [VNUM_W-1:0]    pl_vn, vd_vq, vel_lim;
	logic [MAG_W-1:0]     mag_c, res_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q   <= '0;
			start_q <= '0;
			move_q  <= '0;
			rest_q  <= '0;
			ret_q   <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_AMPLITUDE: amp_q   <= cfg_wdata;
				REG_START:     start_q <= cfg_wdata[TIME_BITS-1:0];
				REG_MOVE:      move_q  <= cfg_wdata[TIME_BITS-1:0];
				REG_REST:      rest_q  <= cfg_wdata[TIME_BITS-1:0];
				REG_RETURN:    ret_q   <= cfg_wdata[TIME_BITS-1:0];
				default:       ;
			endcase
		end
	end

	// whole pipeline advances unless a result is held at the output
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	mjt_seg #(.TB(TIME_BITS)) u_seg (
		.clk(clk), .arst_n(arst_n), .en(adv), .vld_i(in_valid),
		.time_i(sample_time), .func_i(func), .amp_i(amp_q),
		.start_i(start_q), .move_i(move_q), .rest_i(rest_q), .ret_i(ret_q),
		.vld_s1(seg_vld), .ctl_s1(seg_ctl), .e_s1(seg_e), .den_s1(seg_den),
		.full_s1(seg_full)
	);

	mjt_fdiv #(.TB(TIME_BITS)) u_fdiv (
		.clk(clk), .arst_n(arst_n), .en(adv), .vld_i(seg_vld), .ctl_i(seg_ctl),
		.e_i(seg_e), .den_i(seg_den), .full_i(seg_full),
		.vld_o(fd_vld), .ctl_o(fd_ctl), .s_o(fd_s), .den_o(fd_den)
	);

	mjt_poly #(.TB(TIME_BITS)) u_poly (
		.clk(clk), .arst_n(arst_n), .en(adv), .vld_i(fd_vld), .ctl_i(fd_ctl),
		.s_i(fd_s), .den_i(fd_den),
		.vld_s4(pl_vld), .ctl_s4(pl_ctl), .pm_s4(pl_pm), .vn_s4(pl_vn),
		.den_s4(pl_den)
	);

	mjt_vdiv #(.TB(TIME_BITS)) u_vdiv (
		.clk(clk), .arst_n(arst_n), .en(adv), .vld_i(pl_vld), .ctl_i(pl_ctl),
		.pm_i(pl_pm), .vn_i(pl_vn), .den_i(pl_den),
		.vld_o(vd_vld), .ctl_o(vd_ctl), .pm_o(vd_pm), .vq_o(vd_vq)
	);

	assign vel_lim = vd_ctl.neg ? VNUM_W'(40'h0080000000) : VNUM_W'(40'h007FFFFFFF);

	always_comb begin
		unique case (vd_ctl.mode)
			MD_ZERO: mag_c = '0;
			MD_HOLD: mag_c = vd_ctl.mag;
			MD_POS:  mag_c = vd_pm;
			MD_VEL:  mag_c = (vd_vq > vel_lim) ? vel_lim[MAG_W-1:0] : vd_vq[MAG_W-1:0];
			default: mag_c = '0;
		endcase
		res_c = vd_ctl.neg ? (~mag_c + MAG_W'(1)) : mag_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vd_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			setpoint_q <= res_c;
		end
	end

	assign out_valid = out_valid_q;
	assign setpoint  = setpoint_q;

	`MJT_ASSERT_IMPL(a_held_blocks_input, out_valid && out_stall, in_stall)
	`MJT_ASSERT_IMPL(a_empty_takes_input, !out_valid, !in_stall)
	`MJT_ASSERT_NEXT(a_frozen_keeps_item, vd_vld && !adv, vd_vld)

endmodule

`default_nettype wire
